>>> src/gf2m_pkg.sv
// Package for the GF(2^m) arithmetic unit: widths, action codes, cell types.
// Used by the cell, the row and the top level; no dependencies.
package gf2m_pkg;
   localparam int ElemBits   = 32;
   localparam int DegBits    = 6;
   localparam int ActBits    = 3;
   localparam int CsrIdxBits = 1;
   localparam int CntBits    = 6;

   typedef enum logic [ActBits-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_INV = 3'd4
   } action_type;

   localparam logic [CsrIdxBits-1:0] CSR_DEGREE = 1'b0;
   localparam logic [CsrIdxBits-1:0] CSR_POLY   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQR,
      ST_PMUL,
      ST_FMUL,
      ST_DONE
   } state_type;

   // control handed along the row of cells for one multiply
   typedef struct packed {
      logic                start;
      logic [ElemBits-1:0] top;
      logic [ElemBits-1:0] mask;
      logic [ElemBits-1:0] poly;
   } mul_ctl_type;
endpackage

>>> src/gf2m_cell.sv
// One bit-slice cell of the shift-and-add multiplier.
// Depends on gf2m_pkg.
module gf2m_cell (
   input  logic clock,
   input  logic start,
   input  logic shift_in,
   input  logic top_bit,
   input  logic poly_bit,
   input  logic mask_bit,
   input  logic a_bit,
   input  logic b_bit,
   output logic acc_bit
);
   import gf2m_pkg::*;
   logic acc_ff, acc_in;

   // acc = ((acc<<1) ^ (top ? poly : 0)) ^ (b ? a : 0), masked to m bits
   always_comb begin
      acc_in = (shift_in ^ (top_bit & poly_bit)) & mask_bit;
      acc_in = acc_in ^ (b_bit & a_bit);
      if (start) acc_in = b_bit & a_bit;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_bit = acc_ff;
endmodule

>>> src/gf2m_mul_row.sv
// Row of cells doing one reduced product, one bit of b per cycle.
// Depends on gf2m_pkg and gf2m_cell.
module gf2m_mul_row (
   input  logic                          clock,
   input  gf2m_pkg::mul_ctl_type         ctl,
   input  logic [gf2m_pkg::ElemBits-1:0] a,
   input  logic                          b_bit,
   output logic [gf2m_pkg::ElemBits-1:0] acc
);
   import gf2m_pkg::*;
   logic [ElemBits-1:0] shifted;
   logic                top_hit;

   // bit m of the shifted accumulator, i.e. bit m-1 of acc
   assign top_hit = |(acc & ctl.top);
   assign shifted = {acc[ElemBits-2:0], 1'b0};

   for (genvar i = 0; i < ElemBits; i++) begin : g_cell
      gf2m_cell u_cell (
         .clock    (clock),
         .start    (ctl.start),
         .shift_in (shifted[i]),
         .top_bit  (top_hit),
         .poly_bit (ctl.poly[i]),
         .mask_bit (ctl.mask[i]),
         .a_bit    (a[i]),
         .b_bit    (b_bit),
         .acc_bit  (acc[i])
      );
   end
endmodule

>>> src/gf2m_arithmetic_unit.sv
// Top level of the GF(2^m) arithmetic unit: handshakes, sequencer, multiplier row.
// Depends on gf2m_pkg and gf2m_mul_row.
//
// Usage: words enter on req_ (tdata = action, operand_a, operand_b) and one
// result word leaves on rsp_ per request (tdata = result, zero_divisor).
// csr_ writes field_degree (index 0) or reduction_low_terms (index 1); write
// only while idle. Reset restores degree 8 and polynomial 0x1D.
// One item at a time. Add/subtract and zero-divisor cases show the result
// the cycle after accept. The multiplier row consumes one bit of b per cycle;
// the product is copied to the result register in the cycle after its last
// bit, and a following multiply reads it straight from the row in that cycle.
// Inverse: m squarings and m-1 extra multiplies. Divide adds one more
// multiply. req_tready returns the cycle after the result is taken.
// The result sits in an output register until rsp_tready; a stalled receiver
// holds the block and req_tready stays low until the result is taken.
module gf2m_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // action[2:0], operand_a[34:3], operand_b[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result[31:0], zero_divisor[32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [gf2m_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import gf2m_pkg::*;

   logic [DegBits-1:0]  deg_ff;
   logic [ElemBits-1:0] poly_ff;
   state_type           state_ff, state_in;
   logic [ActBits-1:0]  act_ff;
   logic [ElemBits-1:0] a_ff, b_ff, r_ff, r_in;
   logic [CntBits-1:0]  bit_ff, bit_in;     // bit index of b within a multiply
   logic [CntBits-1:0]  exp_ff, exp_in;     // exponent bits left
   logic                zero_ff;
   logic                cap_ff;             // row holds a finished product
   logic [ElemBits-1:0] mop_a, mop_b, acc, r_cur;
   logic [ElemBits-1:0] mask, top;
   logic [CntBits-1:0]  m_eff;
   logic                accept, mul_last, start;
   mul_ctl_type         ctl;
   logic [ElemBits-1:0] in_a, in_b;
   logic [DegBits-1:0]  m_dec;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff  <= 6'd8;
         poly_ff <= 32'd29;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DEGREE) deg_ff  <= csr_data[DegBits-1:0];
         else                         poly_ff <= csr_data;
      end
   end

   // effective degree, kept as m-1 in 6 bits (range 1..31)
   always_comb begin
      if (deg_ff < 6'd2)        m_dec = 6'd1;
      else if (deg_ff > 6'd32)  m_dec = 6'd31;
      else                      m_dec = deg_ff - 6'd1;
      m_eff = m_dec;
      mask  = {ElemBits{1'b1}} >> (5'd31 - m_dec[4:0]);
      top   = 32'd1 << m_dec[4:0];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_a       = req_tdata[34:3] & mask;
   assign in_b       = req_tdata[66:35] & mask;
   assign mul_last   = (bit_ff == 6'd0);

   // running value: the row output in the cycle its product is ready
   assign r_cur = cap_ff ? acc : r_ff;

   // operand selection for the multiplier row
   always_comb begin
      case (state_ff)
         ST_MUL:  begin mop_a = a_ff;  mop_b = b_ff; end
         ST_SQR:  begin mop_a = r_cur; mop_b = r_cur; end
         ST_PMUL: begin mop_a = r_cur; mop_b = (act_ff == ACT_DIV) ? b_ff : a_ff; end
         ST_FMUL: begin mop_a = a_ff;  mop_b = r_cur; end
         default: begin mop_a = a_ff;  mop_b = b_ff; end
      endcase
   end

   assign start = (bit_ff == m_eff);
   assign ctl   = '{start: start, top: top, mask: mask, poly: poly_ff & mask};

   gf2m_mul_row u_row (
      .clock (clock),
      .ctl   (ctl),
      .a     (mop_a),
      .b_bit (mop_b[bit_ff[4:0]]),
      .acc   (acc)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            case (req_tdata[2:0])
               ACT_MUL: state_in = ST_MUL;
               ACT_DIV: state_in = (in_b == '0) ? ST_DONE : ST_SQR;
               ACT_INV: state_in = (in_a == '0) ? ST_DONE : ST_SQR;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL:  if (mul_last) state_in = ST_DONE;
         ST_SQR:  if (mul_last) state_in = (exp_ff != 6'd1) ? ST_PMUL
                                          : ((act_ff == ACT_DIV) ? ST_FMUL : ST_DONE);
         ST_PMUL: if (mul_last) state_in = ST_SQR;
         ST_FMUL: if (mul_last) state_in = ST_DONE;
         ST_DONE: if (rsp_tvalid && rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      r_in   = r_cur;
      bit_in = bit_ff;
      exp_in = exp_ff;
      case (state_ff)
         ST_IDLE: begin
            bit_in = m_eff;
            exp_in = m_eff + 6'd1;
            case (req_tdata[2:0])
               ACT_ADD, ACT_SUB: r_in = in_a ^ in_b;
               ACT_DIV:          r_in = (in_b == '0) ? '0 : 32'd1;
               ACT_INV:          r_in = (in_a == '0) ? '0 : 32'd1;
               default:          r_in = '0;
            endcase
         end
         ST_MUL, ST_SQR, ST_PMUL, ST_FMUL: begin
            bit_in = mul_last ? m_eff : (bit_ff - 6'd1);
            if (mul_last && state_ff == ST_PMUL) exp_in = exp_ff - 6'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= (state_ff != ST_IDLE) && (state_ff != ST_DONE) && mul_last;
      end
      bit_ff <= bit_in;
      exp_ff <= exp_in;
      r_ff   <= r_in;
      if (accept) begin
         act_ff  <= req_tdata[2:0];
         a_ff    <= in_a;
         b_ff    <= in_b;
         zero_ff <= ((req_tdata[2:0] == ACT_DIV) && (in_b == '0))
                 || ((req_tdata[2:0] == ACT_INV) && (in_a == '0));
      end
   end

   assign rsp_tvalid = (state_ff == ST_DONE) && !cap_ff;
   assign rsp_tdata  = {7'd0, zero_ff, r_ff & mask};
endmodule

>>> src/gf2m_checker.sv
// Port-level checker for the GF(2^m) arithmetic unit, bound to the top level.
// Depends on gf2m_arithmetic_unit.
module gf2m_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // a zero divisor always comes with result zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("zero divisor with nonzero result");
   // no new request while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind gf2m_arithmetic_unit gf2m_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
